// ----- rtl/vmr_pkg.sv -----
// vmr_pkg: shared types, codes and helpers of the velocity moment reducer
// no dependencies; imported by every rtl module of the block

package vmr_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CELL_VOL      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TEMP_SCALE    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DENSITY_FLOOR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_VEL_X     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_VEL_Y     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_REF_VEL_Z     = 3'd5;

	localparam logic [31:0] RST_CELL_VOL      = 32'd65536;
	localparam logic [31:0] RST_TEMP_SCALE    = 32'd65536;
	localparam logic [31:0] RST_DENSITY_FLOOR = 32'd1;

	// multiplier operations
	localparam int OP_W = 4;
	localparam logic [OP_W-1:0] OP_SQX = 4'd0;
	localparam logic [OP_W-1:0] OP_SQY = 4'd1;
	localparam logic [OP_W-1:0] OP_SQZ = 4'd2;
	localparam logic [OP_W-1:0] OP_MX  = 4'd3;
	localparam logic [OP_W-1:0] OP_MY  = 4'd4;
	localparam logic [OP_W-1:0] OP_MZ  = 4'd5;
	localparam logic [OP_W-1:0] OP_DLO = 4'd6;
	localparam logic [OP_W-1:0] OP_DHI = 4'd7;
	localparam logic [OP_W-1:0] OP_DNL = 4'd8;
	localparam logic [OP_W-1:0] OP_DNH = 4'd9;
	localparam logic [OP_W-1:0] OP_TLO = 4'd10;
	localparam logic [OP_W-1:0] OP_THI = 4'd11;

	// division jobs
	localparam logic [1:0] DIV_X    = 2'd0;
	localparam logic [1:0] DIV_Y    = 2'd1;
	localparam logic [1:0] DIV_Z    = 2'd2;
	localparam logic [1:0] DIV_TEMP = 2'd3;

	localparam int DIV_STEPS = 32;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic            capture;
		logic            issue;
		logic [OP_W-1:0] op;
		logic            div_start;
		logic [1:0]      div_sel;
		logic            div_store;
		logic            load_out;
		logic            clear;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic empty;
		logic div_done;
	} sts_t;

	function automatic logic [63:0] add_sat_u64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? {64{1'b1}} : s[63:0];
	endfunction

	function automatic logic [63:0] add_sat_s64(input logic [63:0] a, input logic [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			return s[64] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF;
		end
		return s[63:0];
	endfunction

endpackage

// ----- rtl/vmr_if.sv -----
// vmr_if: handshake channels for samples and cell moments
// no dependencies

interface vmr_sample_if;
	logic               valid;
	logic               ready;
	logic        [31:0] sample;
	logic signed [23:0] vel_x;
	logic signed [23:0] vel_y;
	logic signed [23:0] vel_z;
	logic               last_sample;

	modport source(output valid, sample, vel_x, vel_y, vel_z, last_sample, input ready);
	modport sink(input valid, sample, vel_x, vel_y, vel_z, last_sample, output ready);
endinterface

interface vmr_moment_if;
	logic               valid;
	logic               ready;
	logic        [31:0] density;
	logic signed [31:0] mean_vel_x;
	logic signed [31:0] mean_vel_y;
	logic signed [31:0] mean_vel_z;
	logic        [31:0] temperature;
	logic               empty_cell;

	modport source(output valid, density, mean_vel_x, mean_vel_y, mean_vel_z, temperature,
		empty_cell, input ready);
	modport sink(input valid, density, mean_vel_x, mean_vel_y, mean_vel_z, temperature,
		empty_cell, output ready);
endinterface

// ----- rtl/vmr_div.sv -----
// vmr_div: restoring divider, one quotient bit per cycle, quotient saturated to 32 bits
// depends on vmr_pkg

module vmr_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [95:0] num,
	input  logic [63:0] den,
	output logic        done,
	output logic [31:0] quot
);
	import vmr_pkg::*;

	logic [63:0]          rem_q;
	logic [31:0]          nlo_q;
	logic [31:0]          quo_q;
	logic                 ovf_q;
	logic                 run_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [64:0]          r_sh;
	logic [64:0]          r_sub;
	logic                 ge;

	assign r_sh  = {rem_q, nlo_q[31]};
	assign r_sub = r_sh - {1'b0, den};
	assign ge    = r_sh >= {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// quotient of 2^32 or more when the top part already reaches the divisor
			ovf_q <= num[95:32] >= den;
			rem_q <= num[95:32];
			nlo_q <= num[31:0];
			quo_q <= '0;
		end else if (run_q) begin
			rem_q <= ge ? r_sub[63:0] : r_sh[63:0];
			nlo_q <= {nlo_q[30:0], 1'b0};
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign done = done_q;
	assign quot = ovf_q ? {32{1'b1}} : quo_q;
endmodule

// ----- rtl/vmr_dp.sv -----
// vmr_dp: datapath with shared multiplier, accumulators, divider and result registers
// depends on vmr_pkg and vmr_div

module vmr_dp (
	input  logic               clk,
	input  logic               arst_n,
	input  vmr_pkg::cmd_t      cmd,
	output vmr_pkg::sts_t      sts,
	input  logic        [31:0] smp,
	input  logic signed [23:0] vel_x,
	input  logic signed [23:0] vel_y,
	input  logic signed [23:0] vel_z,
	input  logic               last_smp,
	input  logic        [31:0] cell_vol,
	input  logic        [31:0] temp_scale,
	input  logic        [31:0] density_floor,
	input  logic signed [23:0] ref_x,
	input  logic signed [23:0] ref_y,
	input  logic signed [23:0] ref_z,
	output logic        [31:0] density,
	output logic signed [31:0] mean_x,
	output logic signed [31:0] mean_y,
	output logic signed [31:0] mean_z,
	output logic        [31:0] temperature,
	output logic               empty_cell
);
	import vmr_pkg::*;

	logic        [31:0] f_q;
	logic signed [23:0] v_q [3];
	logic signed [24:0] dv_q [3];
	logic               last_q;

	logic [63:0] sum_s_q;
	logic [63:0] mom_q [3];
	logic [63:0] sq_q;
	logic [49:0] dsq_q;
	logic [63:0] tmp_q;
	logic [31:0] dens_q;
	logic [95:0] num_q;
	logic [31:0] mean_q [3];
	logic [31:0] temp_q;

	logic signed [32:0] opa;
	logic signed [32:0] opb;
	logic signed [65:0] prod;
	logic signed [65:0] prod_s1;
	logic [OP_W-1:0]    op_s1;
	logic               vld_s1;

	logic [63:0] dev_add;
	logic [95:0] dens_full;
	logic        emp;

	logic [63:0] mom_sel;
	logic [63:0] mag;
	logic [95:0] div_num;
	logic        div_done;
	logic [31:0] quot;
	logic [31:0] q_neg;

	// operand select for the one shared multiplier
	always_comb begin
		opa = '0;
		opb = '0;
		unique case (cmd.op)
			OP_SQX: begin opa = 33'(dv_q[0]); opb = 33'(dv_q[0]); end
			OP_SQY: begin opa = 33'(dv_q[1]); opb = 33'(dv_q[1]); end
			OP_SQZ: begin opa = 33'(dv_q[2]); opb = 33'(dv_q[2]); end
			OP_MX:  begin opa = {1'b0, f_q}; opb = 33'(v_q[0]); end
			OP_MY:  begin opa = {1'b0, f_q}; opb = 33'(v_q[1]); end
			OP_MZ:  begin opa = {1'b0, f_q}; opb = 33'(v_q[2]); end
			OP_DLO: begin opa = {1'b0, dsq_q[31:0]}; opb = {1'b0, f_q}; end
			OP_DHI: begin opa = {15'b0, dsq_q[49:32]}; opb = {1'b0, f_q}; end
			OP_DNL: begin opa = {1'b0, sum_s_q[31:0]}; opb = {1'b0, cell_vol}; end
			OP_DNH: begin opa = {1'b0, sum_s_q[63:32]}; opb = {1'b0, cell_vol}; end
			OP_TLO: begin opa = {1'b0, sq_q[31:0]}; opb = {1'b0, temp_scale}; end
			OP_THI: begin opa = {1'b0, sq_q[63:32]}; opb = {1'b0, temp_scale}; end
			default: begin opa = '0; opb = '0; end
		endcase
	end

	assign prod = opa * opb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= cmd.issue;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		op_s1   <= cmd.op;
	end

	// (dsq_hi * f) << 32 plus dsq_lo * f, then >> 24
	assign dev_add   = {6'b0, prod_s1[49:0], 8'b0} + {24'b0, tmp_q[63:24]};
	assign dens_full = {prod_s1[63:0], 32'b0} + {32'b0, tmp_q};
	assign emp       = dens_q <= density_floor;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			f_q     <= smp;
			v_q[0]  <= vel_x;
			v_q[1]  <= vel_y;
			v_q[2]  <= vel_z;
			dv_q[0] <= {vel_x[23], vel_x} - {ref_x[23], ref_x};
			dv_q[1] <= {vel_y[23], vel_y} - {ref_y[23], ref_y};
			dv_q[2] <= {vel_z[23], vel_z} - {ref_z[23], ref_z};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q  <= 1'b0;
			sum_s_q <= '0;
			mom_q   <= '{default: '0};
			sq_q    <= '0;
			dsq_q   <= '0;
			tmp_q   <= '0;
			dens_q  <= '0;
			num_q   <= '0;
		end else if (cmd.clear) begin
			sum_s_q <= '0;
			mom_q   <= '{default: '0};
			sq_q    <= '0;
		end else begin
			if (cmd.capture) begin
				last_q  <= last_smp;
				sum_s_q <= add_sat_u64(sum_s_q, {32'b0, smp});
			end
			if (vld_s1) begin
				unique case (op_s1)
					OP_SQX: dsq_q <= prod_s1[49:0];
					OP_SQY, OP_SQZ: dsq_q <= dsq_q + prod_s1[49:0];
					OP_MX:  mom_q[0] <= add_sat_s64(mom_q[0], prod_s1[63:0]);
					OP_MY:  mom_q[1] <= add_sat_s64(mom_q[1], prod_s1[63:0]);
					OP_MZ:  mom_q[2] <= add_sat_s64(mom_q[2], prod_s1[63:0]);
					OP_DLO, OP_DNL: tmp_q <= prod_s1[63:0];
					OP_DHI: sq_q <= add_sat_u64(sq_q, dev_add);
					OP_DNH: dens_q <= (dens_full[95:48] != '0) ? {32{1'b1}} : dens_full[47:16];
					OP_TLO: num_q <= {32'b0, prod_s1[63:0]};
					OP_THI: num_q <= num_q + {prod_s1[63:0], 32'b0};
					default: ;
				endcase
			end
		end
	end

	// division operand and result handling
	always_comb begin
		unique case (cmd.div_sel)
			DIV_X:   mom_sel = mom_q[0];
			DIV_Y:   mom_sel = mom_q[1];
			DIV_Z:   mom_sel = mom_q[2];
			default: mom_sel = mom_q[0];
		endcase
	end

	assign mag     = mom_sel[63] ? 64'd0 - mom_sel : mom_sel;
	assign div_num = (cmd.div_sel == DIV_TEMP) ? num_q : {32'b0, mag};
	assign q_neg   = (quot > 32'h8000_0000) ? 32'h8000_0000 : quot;

	vmr_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (div_num),
		.den   (sum_s_q),
		.done  (div_done),
		.quot  (quot)
	);

	always_ff @(posedge clk) begin
		if (cmd.div_store) begin
			unique case (cmd.div_sel)
				DIV_X: mean_q[0] <= mom_sel[63] ? 32'd0 - q_neg
					: ((quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot);
				DIV_Y: mean_q[1] <= mom_sel[63] ? 32'd0 - q_neg
					: ((quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot);
				DIV_Z: mean_q[2] <= mom_sel[63] ? 32'd0 - q_neg
					: ((quot > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : quot);
				default: temp_q <= quot;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			density     <= dens_q;
			empty_cell  <= emp;
			mean_x      <= emp ? '0 : mean_q[0];
			mean_y      <= emp ? '0 : mean_q[1];
			mean_z      <= emp ? '0 : mean_q[2];
			temperature <= emp ? '0 : temp_q;
		end
	end

	assign sts.last     = last_q;
	assign sts.empty    = emp;
	assign sts.div_done = div_done;
endmodule

// ----- rtl/vmr_ctrl.sv -----
// vmr_ctrl: sequencer for sample accumulation, cell finish, divisions and result hand-off
// depends on vmr_pkg

module vmr_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  vmr_pkg::sts_t sts,
	output vmr_pkg::cmd_t cmd
);
	import vmr_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_SMP   = 3'd1;
	localparam logic [2:0] ST_SDRN  = 3'd2;
	localparam logic [2:0] ST_FIN   = 3'd3;
	localparam logic [2:0] ST_FDRN  = 3'd4;
	localparam logic [2:0] ST_DGO   = 3'd5;
	localparam logic [2:0] ST_DWAIT = 3'd6;
	localparam logic [2:0] ST_EMIT  = 3'd7;

	logic [2:0]      state_q;
	logic [OP_W-1:0] op_q;
	logic [1:0]      sel_q;
	logic            out_valid_q;
	logic            load;

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;
	assign load      = (state_q == ST_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd.capture   = in_valid && (state_q == ST_IDLE);
		cmd.issue     = (state_q == ST_SMP) || (state_q == ST_FIN);
		cmd.op        = op_q;
		cmd.div_start = state_q == ST_DGO;
		cmd.div_sel   = sel_q;
		cmd.div_store = (state_q == ST_DWAIT) && sts.div_done;
		cmd.load_out  = load;
		cmd.clear     = load;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_SQX;
			sel_q       <= DIV_X;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_SQX;
						state_q <= ST_SMP;
					end
				end
				ST_SMP: begin
					op_q <= op_q + 1'b1;
					if (op_q == OP_DHI) begin
						state_q <= ST_SDRN;
					end
				end
				ST_SDRN: begin
					if (sts.last) begin
						op_q    <= OP_DNL;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FIN: begin
					op_q <= op_q + 1'b1;
					if (op_q == OP_THI) begin
						state_q <= ST_FDRN;
					end
				end
				ST_FDRN: begin
					sel_q   <= DIV_X;
					state_q <= sts.empty ? ST_EMIT : ST_DGO;
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (sts.div_done) begin
						if (sel_q == DIV_TEMP) begin
							state_q <= ST_EMIT;
						end else begin
							sel_q   <= sel_q + 1'b1;
							state_q <= ST_DGO;
						end
					end
				end
				ST_EMIT: begin
					if (load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/velocity_moment_reducer.sv -----
// velocity_moment_reducer: top level, configuration registers and checks
// depends on vmr_pkg, vmr_if, vmr_ctrl, vmr_dp
//
// channel   | dir  | payload                                           | transfer when
// ----------+------+---------------------------------------------------+----------------
// samples   | in   | sample, vel_x/y/z, last_sample                    | valid && ready
// moments   | out  | density, mean_vel_x/y/z, temperature, empty_cell  | valid && ready
// cfg       | in   | cfg_index, cfg_data                               | cfg_we
//
// each sample passes through the transfer, eight operations through the one
// 33x33 multiplier (three squares, three first moments, two halves of the
// deviation product) and the drain state ST_SDRN that retires the last
// accumulation; a last sample adds the multiplications for density and the
// temperature numerator and the drain state ST_FDRN, then the bit-serial
// divider for the three mean velocities and the temperature unless the cell
// is empty, then the load of the output register
// arst_n clears the sequencer and accumulators; config registers take reset values
// a result waiting in the output register does not block new samples, only
// the next cell's result

module velocity_moment_reducer (
	input  logic                               clk,
	input  logic                               arst_n,
	vmr_sample_if.sink                         samples,
	vmr_moment_if.source                       moments,
	input  logic                               cfg_we,
	input  logic [vmr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [vmr_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import vmr_pkg::*;

	// configuration registers
	logic        [31:0] cell_vol_q;
	logic        [31:0] temp_scale_q;
	logic        [31:0] density_floor_q;
	logic signed [23:0] ref_vel_x_q;
	logic signed [23:0] ref_vel_y_q;
	logic signed [23:0] ref_vel_z_q;

	cmd_t cmd;
	sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vol_q      <= RST_CELL_VOL;
			temp_scale_q    <= RST_TEMP_SCALE;
			density_floor_q <= RST_DENSITY_FLOOR;
			ref_vel_x_q     <= '0;
			ref_vel_y_q     <= '0;
			ref_vel_z_q     <= '0;
		end else if (cfg_we) begin
			// indexes beyond the list are dropped
			unique case (cfg_index)
				CFG_CELL_VOL:      cell_vol_q      <= cfg_data;
				CFG_TEMP_SCALE:    temp_scale_q    <= cfg_data;
				CFG_DENSITY_FLOOR: density_floor_q <= cfg_data;
				CFG_REF_VEL_X:     ref_vel_x_q     <= cfg_data[23:0];
				CFG_REF_VEL_Y:     ref_vel_y_q     <= cfg_data[23:0];
				CFG_REF_VEL_Z:     ref_vel_z_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// sequencer
	vmr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (samples.valid),
		.in_ready (samples.ready),
		.out_valid(moments.valid),
		.out_ready(moments.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// arithmetic, accumulators and the output register
	vmr_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.smp          (samples.sample),
		.vel_x        (samples.vel_x),
		.vel_y        (samples.vel_y),
		.vel_z        (samples.vel_z),
		.last_smp     (samples.last_sample),
		.cell_vol     (cell_vol_q),
		.temp_scale   (temp_scale_q),
		.density_floor(density_floor_q),
		.ref_x        (ref_vel_x_q),
		.ref_y        (ref_vel_y_q),
		.ref_z        (ref_vel_z_q),
		.density      (moments.density),
		.mean_x       (moments.mean_vel_x),
		.mean_y       (moments.mean_vel_y),
		.mean_z       (moments.mean_vel_z),
		.temperature  (moments.temperature),
		.empty_cell   (moments.empty_cell)
	);

	// a sample transfer always starts an accumulation that holds ready low
	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		samples.valid && samples.ready |=> !samples.ready)
		else $error("sample taken while accumulation in progress");

	// empty cells carry zero mean and temperature
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		moments.valid && moments.empty_cell |->
		moments.mean_vel_x == 0 && moments.mean_vel_y == 0 &&
		moments.mean_vel_z == 0 && moments.temperature == 0)
		else $error("empty cell with non-zero moments");

	// a non-empty cell has density above the floor
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		moments.valid && !moments.empty_cell |-> moments.density > density_floor_q)
		else $error("density at or below floor not flagged empty");
endmodule
